### sv/sccb_register_access_master_macros.svh
// ----------------------------------------------------------------------------
// SCCB register access master: assertion macros
// Shared property wrappers; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SCCB_REGISTER_ACCESS_MASTER_MACROS_SVH
`define SCCB_REGISTER_ACCESS_MASTER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SCRAM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define SCRAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/scram_pkg.sv
// ----------------------------------------------------------------------------
// scram_pkg
// Types and constants shared by the SCCB register access master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scram_pkg;

  // Request payload: one bus timebase tick
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] reg_address;
    logic [7:0]  write_data;
    logic        sda_sample;
  } in_item_t;

  // Result payload: line state and completion info for one tick
  typedef struct packed {
    logic       scl;
    logic       sda_drive;
    logic       sda_output_enable;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] read_data;
  } out_item_t;

  // Bus sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_WBIT  = 3'd2,
    PH_ACK   = 3'd3,
    PH_STOP  = 3'd4,
    PH_RBIT  = 3'd5,
    PH_NACK  = 3'd6
  } phase_t;

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DEV_NACK  = 3'd1;
  localparam logic [2:0] ST_HIGH_NACK = 3'd2;
  localparam logic [2:0] ST_LOW_NACK  = 3'd3;
  localparam logic [2:0] ST_DATA_NACK = 3'd4;

  // Byte slots in a transaction
  localparam logic [2:0] BYTE_DEV   = 3'd0;
  localparam logic [2:0] BYTE_HIGH  = 3'd1;
  localparam logic [2:0] BYTE_LOW   = 3'd2;
  localparam logic [2:0] BYTE_DATA  = 3'd3;
  localparam logic [2:0] BYTE_RDDEV = 3'd4;

  // Configuration register map
  localparam logic       REG_IDX_DEVICE  = 1'b0;
  localparam logic [7:0] DEV_ADDR_RESET  = 8'd120;
  localparam logic [7:0] DEV_READ_FLAG   = 8'h01;
  localparam logic [7:0] DEV_WRITE_FLAG  = 8'h00;
  localparam logic [7:0] SHIFT_MSB_MASK  = 8'h80;

endpackage

### sv/sccb_register_access_master.sv
// ----------------------------------------------------------------------------
// sccb_register_access_master
// SCCB master for 16-bit register addresses, one bus tick per request.
//
//   channel  | ports                               | moves
//   ---------+-------------------------------------+--------------------------
//   input    | in_valid / in_ready / in_data       | one tick: cmd + SDA sample
//   result   | out_valid / out_ready / out_data    | line levels and status
//   config   | psel penable pwrite paddr pwdata .. | device address register
//
// One request per clock while results are taken; a request passes the input
// register, then the sequencer step into the result register.
// Synchronous active-low reset: lines idle high and driven, no request held.
// A stalled result holds; the input register keeps taking requests until it
// is also full, then in_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sccb_register_access_master (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  scram_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output scram_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import scram_pkg::*;

  logic      s1_valid_r;
  in_item_t  s1_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t step_res;
  logic      advance;
  logic [7:0] device_address;

  // configuration registers
  scram_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .device_address (device_address)
  );

  // stage handshake
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // bit sequencer
  scram_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (advance),
    .item           (s1_data_r),
    .device_address (device_address),
    .res            (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/scram_cfg.sv
// ----------------------------------------------------------------------------
// scram_cfg
// APB-style register file holding the SCCB device address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scram_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  device_address
);
  import scram_pkg::*;

  logic [7:0] dev_addr_r;
  logic       wr_en;
  logic       sel_dev;

  // register index sits above the byte offset
  assign sel_dev = (paddr[2] == REG_IDX_DEVICE);
  assign wr_en   = psel && penable && pwrite && sel_dev;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RESET;
    end else if (wr_en) begin
      dev_addr_r <= pwdata[7:0];
    end
  end

  // read back; unmapped addresses read zero
  assign prdata         = sel_dev ? {24'd0, dev_addr_r} : 32'd0;
  assign device_address = dev_addr_r;

endmodule

### sv/scram_seq.sv
// ----------------------------------------------------------------------------
// scram_seq
// SCCB bit sequencer: advances one waveform step per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sccb_register_access_master_macros.svh"

module scram_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  scram_pkg::in_item_t  item,
  input  logic [7:0]           device_address,
  output scram_pkg::out_item_t res
);
  import scram_pkg::*;

  phase_t      phase_r,        phase_nxt;
  logic [1:0]  sub_tick_r,     sub_tick_nxt;
  logic [3:0]  bit_count_r,    bit_count_nxt;
  logic [2:0]  byte_index_r,   byte_index_nxt;
  logic [7:0]  shift_out_r,    shift_out_nxt;
  logic [7:0]  shift_in_r,     shift_in_nxt;
  logic [15:0] held_address_r, held_address_nxt;
  logic [7:0]  held_data_r,    held_data_nxt;
  logic        is_read_r,      is_read_nxt;
  logic [2:0]  error_code_r,   error_code_nxt;
  logic        lv_scl_r,       lv_scl_nxt;
  logic        lv_sda_r,       lv_sda_nxt;
  logic        lv_oe_r,        lv_oe_nxt;
  logic        done;

  // byte to send for a given slot
  function automatic logic [7:0] byte_sel(input logic [2:0]  idx,
                                          input logic [7:0]  dev,
                                          input logic [15:0] addr,
                                          input logic [7:0]  data);
    logic [7:0] b;
    case (idx)
      BYTE_DEV:  b = dev | DEV_WRITE_FLAG;
      BYTE_HIGH: b = addr[15:8];
      BYTE_LOW:  b = addr[7:0];
      BYTE_DATA: b = data;
      default:   b = dev | DEV_READ_FLAG;
    endcase
    return b;
  endfunction

  // ack failure code for a byte slot
  function automatic logic [2:0] nack_code(input logic [2:0] idx);
    logic [2:0] c;
    case (idx)
      BYTE_DEV:  c = ST_DEV_NACK;
      BYTE_HIGH: c = ST_HIGH_NACK;
      BYTE_LOW:  c = ST_LOW_NACK;
      default:   c = ST_DATA_NACK;
    endcase
    return c;
  endfunction

  // next state and line levels for one tick
  always_comb begin
    phase_t     ph;
    logic [3:0] bc_inc;
    phase_nxt        = phase_r;
    sub_tick_nxt     = sub_tick_r;
    bit_count_nxt    = bit_count_r;
    byte_index_nxt   = byte_index_r;
    shift_out_nxt    = shift_out_r;
    shift_in_nxt     = shift_in_r;
    held_address_nxt = held_address_r;
    held_data_nxt    = held_data_r;
    is_read_nxt      = is_read_r;
    error_code_nxt   = error_code_r;
    lv_scl_nxt       = lv_scl_r;
    lv_sda_nxt       = lv_sda_r;
    lv_oe_nxt        = lv_oe_r;
    done             = 1'b0;

    // a command in idle starts on this same tick
    if (phase_r == PH_IDLE && (item.cmd == CMD_WRITE || item.cmd == CMD_READ)) begin
      held_address_nxt = item.reg_address;
      held_data_nxt    = item.write_data;
      is_read_nxt      = (item.cmd == CMD_READ);
      error_code_nxt   = ST_OK;
      shift_in_nxt     = 8'd0;
      byte_index_nxt   = BYTE_DEV;
      bit_count_nxt    = 4'd0;
      sub_tick_nxt     = 2'd0;
      phase_nxt        = PH_START;
    end

    ph     = phase_nxt;
    bc_inc = bit_count_nxt + 4'd1;

    unique case (ph)
      PH_IDLE: begin
        // lines hold their levels
      end
      PH_START: begin
        lv_oe_nxt  = 1'b1;
        lv_scl_nxt = 1'b1;
        if (sub_tick_nxt == 2'd0) begin
          lv_sda_nxt   = 1'b1;
          sub_tick_nxt = 2'd1;
        end else begin
          lv_sda_nxt    = 1'b0;
          shift_out_nxt = byte_sel(byte_index_nxt, device_address,
                                   held_address_nxt, held_data_nxt);
          bit_count_nxt = 4'd0;
          sub_tick_nxt  = 2'd0;
          phase_nxt     = PH_WBIT;
        end
      end
      PH_WBIT: begin
        lv_oe_nxt  = 1'b1;
        lv_sda_nxt = |(shift_out_nxt & SHIFT_MSB_MASK);
        if (sub_tick_nxt == 2'd0) begin
          lv_scl_nxt   = 1'b0;
          sub_tick_nxt = 2'd1;
        end else begin
          lv_scl_nxt    = 1'b1;
          sub_tick_nxt  = 2'd0;
          shift_out_nxt = {shift_out_nxt[6:0], 1'b0};
          bit_count_nxt = bc_inc;
          if (bc_inc[3]) begin
            bit_count_nxt = 4'd0;
            phase_nxt     = PH_ACK;
          end
        end
      end
      PH_ACK: begin
        lv_oe_nxt = 1'b0;
        if (sub_tick_nxt == 2'd0) begin
          lv_scl_nxt   = 1'b0;
          sub_tick_nxt = 2'd1;
        end else begin
          lv_scl_nxt   = 1'b1;
          sub_tick_nxt = 2'd0;
          if (item.sda_sample) begin
            error_code_nxt = nack_code(byte_index_nxt);
          end
          if (byte_index_nxt == BYTE_RDDEV) begin
            shift_in_nxt  = 8'd0;
            bit_count_nxt = 4'd0;
            phase_nxt     = PH_RBIT;
          end else if (byte_index_nxt == BYTE_DEV || byte_index_nxt == BYTE_HIGH ||
                       (byte_index_nxt == BYTE_LOW && !is_read_nxt)) begin
            // move on to the next byte
            byte_index_nxt = byte_index_nxt + 3'd1;
            shift_out_nxt  = byte_sel(byte_index_nxt, device_address,
                                      held_address_nxt, held_data_nxt);
            bit_count_nxt  = 4'd0;
            phase_nxt      = PH_WBIT;
          end else begin
            byte_index_nxt = BYTE_DATA;
            phase_nxt      = PH_STOP;
          end
        end
      end
      PH_RBIT: begin
        lv_oe_nxt = 1'b0;
        if (sub_tick_nxt == 2'd0) begin
          lv_scl_nxt   = 1'b0;
          sub_tick_nxt = 2'd1;
        end else begin
          lv_scl_nxt    = 1'b1;
          sub_tick_nxt  = 2'd0;
          shift_in_nxt  = {shift_in_nxt[6:0], item.sda_sample};
          bit_count_nxt = bc_inc;
          if (bc_inc[3]) begin
            bit_count_nxt = 4'd0;
            phase_nxt     = PH_NACK;
          end
        end
      end
      PH_NACK: begin
        lv_oe_nxt  = 1'b1;
        lv_sda_nxt = 1'b1;
        if (sub_tick_nxt == 2'd0) begin
          lv_scl_nxt   = 1'b0;
          sub_tick_nxt = 2'd1;
        end else begin
          lv_scl_nxt   = 1'b1;
          sub_tick_nxt = 2'd0;
          phase_nxt    = PH_STOP;
        end
      end
      PH_STOP: begin
        lv_oe_nxt = 1'b1;
        if (sub_tick_nxt == 2'd0) begin
          lv_scl_nxt   = 1'b0;
          lv_sda_nxt   = 1'b0;
          sub_tick_nxt = 2'd1;
        end else if (sub_tick_nxt == 2'd1) begin
          lv_scl_nxt   = 1'b1;
          lv_sda_nxt   = 1'b0;
          sub_tick_nxt = 2'd2;
        end else begin
          lv_scl_nxt   = 1'b1;
          lv_sda_nxt   = 1'b1;
          sub_tick_nxt = 2'd0;
          // a read restarts after the address part
          if (is_read_nxt && byte_index_nxt == BYTE_DATA) begin
            byte_index_nxt = BYTE_RDDEV;
            phase_nxt      = PH_START;
          end else begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt    = PH_IDLE;
        sub_tick_nxt = 2'd0;
        lv_scl_nxt   = 1'b1;
        lv_sda_nxt   = 1'b1;
        lv_oe_nxt    = 1'b1;
      end
    endcase
  end

  // result for this tick
  always_comb begin
    res.scl               = lv_scl_nxt;
    res.sda_drive         = lv_sda_nxt;
    res.sda_output_enable = lv_oe_nxt;
    res.busy_res          = (phase_nxt != PH_IDLE);
    res.done_res          = done;
    res.status            = done ? error_code_nxt : ST_OK;
    res.read_data         = (done && is_read_nxt) ? shift_in_nxt : 8'd0;
  end

  // state registers advance once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      sub_tick_r     <= 2'd0;
      bit_count_r    <= 4'd0;
      byte_index_r   <= BYTE_DEV;
      shift_out_r    <= 8'd0;
      shift_in_r     <= 8'd0;
      held_address_r <= 16'd0;
      held_data_r    <= 8'd0;
      is_read_r      <= 1'b0;
      error_code_r   <= ST_OK;
      lv_scl_r       <= 1'b1;
      lv_sda_r       <= 1'b1;
      lv_oe_r        <= 1'b1;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      sub_tick_r     <= sub_tick_nxt;
      bit_count_r    <= bit_count_nxt;
      byte_index_r   <= byte_index_nxt;
      shift_out_r    <= shift_out_nxt;
      shift_in_r     <= shift_in_nxt;
      held_address_r <= held_address_nxt;
      held_data_r    <= held_data_nxt;
      is_read_r      <= is_read_nxt;
      error_code_r   <= error_code_nxt;
      lv_scl_r       <= lv_scl_nxt;
      lv_sda_r       <= lv_sda_nxt;
      lv_oe_r        <= lv_oe_nxt;
    end
  end

  // checks
  `SCRAM_ASSERT_NOW(a_done_not_busy, step_en && res.done_res, !res.busy_res, "done while busy")
  `SCRAM_ASSERT_NEXT(a_done_to_idle, step_en && res.done_res, phase_r == PH_IDLE, "done not idle")
  `SCRAM_ASSERT_NOW(a_subtick_range, phase_r != PH_STOP, sub_tick_r <= 2'd1, "sub tick overrun")
  `SCRAM_ASSERT_NOW(a_bitcount_range, 1'b1, bit_count_r <= 4'd7, "bit count overrun")
  `SCRAM_ASSERT_NOW(a_released_in_rx, phase_r == PH_RBIT || phase_r == PH_ACK,
                    !lv_oe_r || sub_tick_r == 2'd0, "sda driven during receive")

endmodule

### verif/sccb_access_checker.sv
// ----------------------------------------------------------------------------
// sccb_access_checker
// Watches both channels and the config port of the SCCB register access
// master. It predicts each tick's line state and completion fields and
// compares every accepted result in order against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sccb_access_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  scram_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  scram_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  input  logic [31:0]          prdata,
  input  logic                 pready,
  output int                   mismatch_count = 0,
  output int                   pending_ticks = 0
);
  import scram_pkg::*;

  localparam logic [2:0] DEV_REG_ADDR = {REG_IDX_DEVICE, 2'b00};

  // Shadow of the device address register
  logic [7:0]  dev_addr;

  // Shadow sequencer state
  phase_t      seq_phase;
  logic [1:0]  seq_sub;
  logic [3:0]  seq_bits;
  logic [2:0]  seq_byte;
  logic [7:0]  tx_shift;
  logic [7:0]  rx_shift;
  logic [15:0] held_addr;
  logic [7:0]  held_data;
  logic        held_read;
  logic [2:0]  err_code;
  logic        line_scl, line_sda, line_oe;

  out_item_t   expected_ticks[$];
  out_item_t   predicted, wanted;
  int          result_index = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h expected %0h",
                                result_index, name, got, want));
  endtask

  function automatic logic [7:0] byte_value(input logic [2:0] idx);
    case (idx)
      BYTE_DEV:  return dev_addr | DEV_WRITE_FLAG;
      BYTE_HIGH: return held_addr[15:8];
      BYTE_LOW:  return held_addr[7:0];
      BYTE_DATA: return held_data;
      default:   return dev_addr | DEV_READ_FLAG;
    endcase
  endfunction

  task automatic load_byte(input logic [2:0] idx);
    seq_byte  = idx;
    tx_shift  = byte_value(idx);
    seq_bits  = '0;
    seq_sub   = '0;
    seq_phase = PH_WBIT;
  endtask

  // One bus tick of the sequencer: advances the shadow state and returns
  // the line levels and completion fields for this tick.
  task automatic step_sequencer(input in_item_t req, output out_item_t res);
    logic       done;
    logic [2:0] b;
    done = 1'b0;

    // A command is only taken in idle, and starts on the same tick
    if (seq_phase == PH_IDLE && (req.cmd == CMD_WRITE || req.cmd == CMD_READ)) begin
      held_addr = req.reg_address;
      held_data = req.write_data;
      held_read = (req.cmd == CMD_READ);
      err_code  = ST_OK;
      rx_shift  = '0;
      seq_byte  = BYTE_DEV;
      seq_bits  = '0;
      seq_sub   = '0;
      seq_phase = PH_START;
    end

    case (seq_phase)
      PH_START: begin
        line_oe  = 1'b1;
        line_scl = 1'b1;
        if (seq_sub == 0) begin
          line_sda = 1'b1;
          seq_sub  = 1;
        end else begin
          line_sda = 1'b0;
          load_byte(seq_byte);
        end
      end
      PH_WBIT: begin
        line_oe  = 1'b1;
        line_sda = (tx_shift & SHIFT_MSB_MASK) != 0;
        if (seq_sub == 0) begin
          line_scl = 1'b0;
          seq_sub  = 1;
        end else begin
          line_scl = 1'b1;
          seq_sub  = 0;
          tx_shift = tx_shift << 1;
          seq_bits = seq_bits + 4'd1;
          if (seq_bits >= 8) begin
            seq_bits  = '0;
            seq_phase = PH_ACK;
          end
        end
      end
      PH_ACK: begin
        line_oe = 1'b0;
        if (seq_sub == 0) begin
          line_scl = 1'b0;
          seq_sub  = 1;
        end else begin
          b        = seq_byte;
          line_scl = 1'b1;
          seq_sub  = 0;
          // high SDA on the ack slot is a NACK; the latest one wins
          if (req.sda_sample) begin
            case (b)
              BYTE_DEV:  err_code = ST_DEV_NACK;
              BYTE_HIGH: err_code = ST_HIGH_NACK;
              BYTE_LOW:  err_code = ST_LOW_NACK;
              default:   err_code = ST_DATA_NACK;
            endcase
          end
          if (b == BYTE_RDDEV) begin
            rx_shift  = '0;
            seq_bits  = '0;
            seq_phase = PH_RBIT;
          end else if (b < BYTE_LOW || (b == BYTE_LOW && !held_read)) begin
            load_byte(b + 3'd1);
          end else begin
            seq_byte  = BYTE_DATA;
            seq_phase = PH_STOP;
          end
        end
      end
      PH_RBIT: begin
        line_oe = 1'b0;
        if (seq_sub == 0) begin
          line_scl = 1'b0;
          seq_sub  = 1;
        end else begin
          line_scl = 1'b1;
          seq_sub  = 0;
          rx_shift = {rx_shift[6:0], req.sda_sample};
          seq_bits = seq_bits + 4'd1;
          if (seq_bits >= 8) begin
            seq_bits  = '0;
            seq_phase = PH_NACK;
          end
        end
      end
      PH_NACK: begin
        line_oe  = 1'b1;
        line_sda = 1'b1;
        if (seq_sub == 0) begin
          line_scl = 1'b0;
          seq_sub  = 1;
        end else begin
          line_scl  = 1'b1;
          seq_sub   = 0;
          seq_phase = PH_STOP;
        end
      end
      PH_STOP: begin
        line_oe = 1'b1;
        if (seq_sub == 0) begin
          line_scl = 1'b0;
          line_sda = 1'b0;
          seq_sub  = 1;
        end else if (seq_sub == 1) begin
          line_scl = 1'b1;
          line_sda = 1'b0;
          seq_sub  = 2;
        end else begin
          line_scl = 1'b1;
          line_sda = 1'b1;
          seq_sub  = 0;
          // a read restarts for the data phase after the address stop
          if (held_read && seq_byte == BYTE_DATA) begin
            seq_byte  = BYTE_RDDEV;
            seq_phase = PH_START;
          end else begin
            seq_phase = PH_IDLE;
            done      = 1'b1;
          end
        end
      end
      default: begin
        seq_phase = PH_IDLE;
        seq_sub   = 0;
        line_scl  = 1'b1;
        line_sda  = 1'b1;
        line_oe   = 1'b1;
      end
    endcase

    res.scl               = line_scl;
    res.sda_drive         = line_sda;
    res.sda_output_enable = line_oe;
    res.busy_res          = (seq_phase != PH_IDLE);
    res.done_res          = done;
    res.status            = done ? err_code : ST_OK;
    res.read_data         = (done && held_read) ? rx_shift : 8'h00;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dev_addr  = DEV_ADDR_RESET;
      seq_phase = PH_IDLE;
      seq_sub   = '0;
      seq_bits  = '0;
      seq_byte  = BYTE_DEV;
      tx_shift  = '0;
      rx_shift  = '0;
      held_addr = '0;
      held_data = '0;
      held_read = 1'b0;
      err_code  = ST_OK;
      line_scl  = 1'b1;
      line_sda  = 1'b1;
      line_oe   = 1'b1;
      expected_ticks.delete();
      pending_ticks <= 0;
    end else begin
      // Result side: compare against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_ticks.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                    result_index));
        end else begin
          wanted = expected_ticks.pop_front();
          check_field("scl", out_data.scl, wanted.scl);
          check_field("sda_drive", out_data.sda_drive, wanted.sda_drive);
          check_field("sda_output_enable", out_data.sda_output_enable,
                      wanted.sda_output_enable);
          check_field("busy_res", out_data.busy_res, wanted.busy_res);
          check_field("done_res", out_data.done_res, wanted.done_res);
          check_field("status", out_data.status, wanted.status);
          check_field("read_data", out_data.read_data, wanted.read_data);
        end
        result_index++;
      end

      // Request side: one predicted result per accepted tick
      if (in_valid && in_ready) begin
        step_sequencer(in_data, predicted);
        expected_ticks.push_back(predicted);
      end

      // Config port: track writes, check read-back
      if (psel && penable && pready && paddr == DEV_REG_ADDR) begin
        if (pwrite)
          dev_addr = pwdata[7:0];
        else if (prdata[7:0] !== dev_addr)
          report_mismatch($sformatf("device address read %0h expected %0h",
                                    prdata[7:0], dev_addr));
      end

      pending_ticks <= expected_ticks.size();
    end
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the SCCB register access master. Drives write and
// read register transactions tick by tick with controlled ACK/NACK slots,
// idle noise and ignored commands, across several device addresses and
// backpressure mixes; the checker does all prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import scram_pkg::*;

  localparam logic [2:0] DEV_REG_ADDR = {REG_IDX_DEVICE, 2'b00};
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  // Transaction shape in ticks
  localparam int WRITE_TICKS  = 77;
  localparam int READ_TICKS   = 100;
  localparam int FIRST_ACK    = 19;
  localparam int BYTE_TICKS   = 18;
  localparam int READ_DEV_ACK = 78;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int pending_ticks;
  int send_gap_pct = 0;
  int stall_pct    = 0;
  int sent_count   = 0;
  int cycle_count  = 0;

  sccb_register_access_master DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  sccb_access_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .mismatch_count(mismatch_count),
    .pending_ticks (pending_ticks)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver backpressure
  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

  // Run-length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Which ack slot a tick offset lands on, -1 if none
  function automatic int ack_slot(input int t, input logic rd);
    if (rd && t == READ_DEV_ACK) return 3;
    if (t >= FIRST_ACK && (t - FIRST_ACK) % BYTE_TICKS == 0 &&
        (t - FIRST_ACK) / BYTE_TICKS < (rd ? 3 : 4))
      return (t - FIRST_ACK) / BYTE_TICKS;
    return -1;
  endfunction

  // One request, with an optional random sender gap in front
  task automatic send_tick(input logic [1:0] c, input logic [15:0] a,
                           input logic [7:0] d, input logic s);
    in_item_t req;
    req.cmd         = c;
    req.reg_address = a;
    req.write_data  = d;
    req.sda_sample  = s;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // Hold off the sender until every predicted result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_ticks != 0);
  endtask

  task automatic cfg_access(input logic wr, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= DEV_REG_ADDR;
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Change the device address only with the sequencer idle and nothing queued
  task automatic set_device_address(input logic [7:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_access(1'b1, value);
    cfg_access(1'b0, value);
  endtask

  // Full register transaction; nack_mask bit k drives the k-th ack slot
  task automatic run_transaction(input logic rd, input logic [15:0] addr,
                                 input logic [7:0] data, input logic [3:0] nack_mask,
                                 input logic busy_noise);
    int         n_ticks;
    int         slot;
    logic [1:0] c;
    logic       s;
    n_ticks = rd ? READ_TICKS : WRITE_TICKS;
    for (int t = 0; t < n_ticks; t++) begin
      slot = ack_slot(t, rd);
      s = (slot >= 0) ? nack_mask[slot] : 1'($urandom_range(0, 1));
      if (t == 0)
        c = rd ? CMD_READ : CMD_WRITE;
      else if (busy_noise && $urandom_range(0, 3) == 0)
        c = 2'($urandom_range(0, 3));
      else
        c = CMD_TICK;
      send_tick(c, (t == 0) ? addr : 16'($urandom), (t == 0) ? data : 8'($urandom), s);
    end
  endtask

  // Idle ticks, plain or carrying the unused command code
  task automatic idle_noise(input int n);
    repeat (n)
      send_tick($urandom_range(0, 1) ? CMD_UNUSED : CMD_TICK, 16'($urandom),
                8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int         pick;
    int         start_items;
    logic [3:0] mask;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset value read-back, field extremes, each NACK slot
    send_gap_pct = 10;
    stall_pct    = 10;
    cfg_access(1'b0, DEV_ADDR_RESET);
    idle_noise(3);
    run_transaction(1'b0, 16'hFFFF, 8'hFF, 4'h0, 1'b0);
    run_transaction(1'b0, 16'h0000, 8'h00, 4'hF, 1'b0);
    run_transaction(1'b1, 16'h0000, 8'h00, 4'h0, 1'b0);
    run_transaction(1'b1, 16'hFFFF, 8'hFF, 4'b0001, 1'b0);
    run_transaction(1'b0, 16'hA55A, 8'h5A, 4'b0010, 1'b0);
    run_transaction(1'b0, 16'h5AA5, 8'hA5, 4'b0100, 1'b1);
    run_transaction(1'b1, 16'h8001, 8'h7E, 4'b1000, 1'b1);
    run_transaction(1'b1, 16'h1234, 8'h00, 4'b0111, 1'b0);
    set_device_address(8'h00);
    run_transaction(1'b0, 16'h0F0F, 8'hC3, 4'h0, 1'b0);
    run_transaction(1'b1, 16'hF0F0, 8'h3C, 4'h0, 1'b0);

    // Random: three backpressure mixes, each with its own device address
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_gap_pct = 15;
          stall_pct    = 60;
          set_device_address(8'd254);
        end
        1: begin
          send_gap_pct = 60;
          stall_pct    = 15;
          set_device_address(8'($urandom_range(1, 253)));
        end
        default: begin
          send_gap_pct = 0;
          stall_pct    = 0;
          set_device_address(DEV_ADDR_RESET);
        end
      endcase
      start_items = sent_count;
      while (sent_count - start_items < 100) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          mask = $urandom_range(0, 1) ? 4'h0 : 4'($urandom);
          run_transaction(pick < 42, 16'($urandom), 8'($urandom), mask,
                          $urandom_range(0, 3) == 0);
          if ($urandom_range(0, 7) == 0) wait_drained();
        end else begin
          idle_noise($urandom_range(1, 6));
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/scram_pkg.sv
sv/scram_cfg.sv
sv/scram_seq.sv
sv/sccb_register_access_master.sv
verif/sccb_access_checker.sv
verif/tb_top.sv
